[design/kwwp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwwp_pkg
// Shared types, register indexes and sequencer states of the K-weighted
// window power block.
// ----------------------------------------------------------------------------
package kwwp_pkg;

   localparam int MaxChannels   = 8;
   localparam int MomentaryBlks = 4;
   localparam int ShortBlks     = 30;
   localparam int ChanBits      = 3;
   localparam int StateDepth    = MaxChannels * 4;
   localparam int StateAddrBits = $clog2(StateDepth);
   localparam int RingAddrBits  = $clog2(ShortBlks);
   localparam int CountBits     = $clog2(ShortBlks + 1);

   localparam logic [2:0] REG_FRAMES = 3'd0;
   localparam logic [2:0] REG_SH_B0  = 3'd1;
   localparam logic [2:0] REG_SH_B1  = 3'd2;
   localparam logic [2:0] REG_SH_B2  = 3'd3;
   localparam logic [2:0] REG_SH_A1  = 3'd4;
   localparam logic [2:0] REG_SH_A2  = 3'd5;
   localparam logic [2:0] REG_HP_A1  = 3'd6;
   localparam logic [2:0] REG_HP_A2  = 3'd7;

   typedef struct packed {
      logic signed [23:0] sample;
      logic [2:0]         channel;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic [47:0] momentary_power;
      logic        momentary_valid;
      logic [47:0] short_power;
      logic        short_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
      ST_M_B0, ST_SHELVED,
      ST_M_B1, ST_M_A1, ST_S0,
      ST_M_B2, ST_M_A2, ST_S1,
      ST_WEIGHTED, ST_M_HA1, ST_S2, ST_M_HA2, ST_S3,
      ST_SQ, ST_ACC,
      ST_FRAME, ST_DIV, ST_RING, ST_SUM, ST_WDIV, ST_OUT
   } state_type;

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > 64'sd140737488355327)       return 48'sh7FFFFFFFFFFF;
      else if (v < -64'sd140737488355328) return 48'sh800000000000;
      else                                return v[47:0];
   endfunction

   function automatic logic signed [31:0] to_q24(input logic signed [63:0] q40);
      logic signed [63:0] r;
      r = (q40 + 64'sd32768) >>> 16;
      if (r > 64'sd2147483647)       return 32'sh7FFFFFFF;
      else if (r < -64'sd2147483648) return 32'sh80000000;
      else                           return r[31:0];
   endfunction

endpackage

[design/k_weighted_window_power.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_weighted_window_power
// K-weighting biquads, sub-block mean square and sliding window powers.
// ----------------------------------------------------------------------------
// Each transaction passes an idle state, a read of the channel's filter state,
// and seven products plus the square through one shared 32x32 multiplier,
// which sets the pace. A transaction that closes a sub-block adds:
//    - a bit-serial divide of the power sum by the frame count,
//    - one ring write,
//    - a walk of the sub-block ring,
//    - shift-and-add steps that divide the thirty-entry sum,
//    - an output state that waits while the last result is held and not taken.
// The four-entry mean is a shift. A result transaction waits in the output
// register while the next request is already taken. The filter state and the
// ring are cleared while reset is high.
module k_weighted_window_power import kwwp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [15:0]        frames_ff;
   logic signed [31:0] coef_ff [7];

   state_type state_ff, state_in;

   logic signed [47:0] fstate_mem [StateDepth];
   logic signed [47:0] rd_data_ff;
   logic [StateAddrBits-1:0] rd_addr, wr_addr;
   logic signed [47:0] wr_data;
   logic               wr_en;
   logic [47:0]        ring_mem [ShortBlks];
   logic [47:0]        ring_rd_ff;
   logic [RingAddrBits-1:0] ring_rd_addr;

   req_type            item_ff;
   logic signed [47:0] st_ff [4];
   logic signed [31:0] shelved_ff, weighted_ff;
   logic signed [47:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] mul_a, mul_b;
   logic [63:0]        power_sum_ff;
   logic [15:0]        frame_cnt_ff;
   logic [RingAddrBits-1:0] ring_pos_ff;
   logic [CountBits-1:0]    done_ff;
   logic [6:0]         step_ff;
   logic [63:0]        quo_ff, rem_ff, div_den_ff;
   logic [53:0]        wsum_m_ff, wsum_s_ff;
   logic [47:0]        mean_m_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [15:0]        eff;
   logic [64:0]        rem_try;

   assign eff = (frames_ff == 16'd0) ? 16'd1 : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff  <= 16'd4800;
         coef_ff[0] <= 32'sd412081942;
         coef_ff[1] <= -32'sd722546696;
         coef_ff[2] <= 32'sd321691119;
         coef_ff[3] <= -32'sd453832898;
         coef_ff[4] <= 32'sd196623810;
         coef_ff[5] <= -32'sd534199295;
         coef_ff[6] <= 32'sd265770496;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAMES: frames_ff <= csr_data[15:0];
            REG_SH_B0, REG_SH_B1, REG_SH_B2, REG_SH_A1, REG_SH_A2, REG_HP_A1,
            REG_HP_A2: coef_ff[csr_index - 3'd1] <= csr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid && req_ready)
                         state_in = ({1'b0, req_data.channel} <
                                     (ChanBits + 1)'(MaxChannels)) ? ST_RD0 : ST_FRAME;
         ST_RD0:      state_in = ST_RD1;
         ST_RD1:      state_in = ST_RD2;
         ST_RD2:      state_in = ST_RD3;
         ST_RD3:      state_in = ST_M_B0;
         ST_M_B0:     state_in = ST_SHELVED;
         ST_SHELVED:  state_in = ST_M_B1;
         ST_M_B1:     state_in = ST_M_A1;
         ST_M_A1:     state_in = ST_S0;
         ST_S0:       state_in = ST_M_B2;
         ST_M_B2:     state_in = ST_M_A2;
         ST_M_A2:     state_in = ST_S1;
         ST_S1:       state_in = ST_WEIGHTED;
         ST_WEIGHTED: state_in = ST_M_HA1;
         ST_M_HA1:    state_in = ST_S2;
         ST_S2:       state_in = ST_M_HA2;
         ST_M_HA2:    state_in = ST_S3;
         ST_S3:       state_in = ST_SQ;
         ST_SQ:       state_in = ST_ACC;
         ST_ACC:      state_in = ST_FRAME;
         ST_FRAME:    state_in = (item_ff.frame_end && (frame_cnt_ff + 16'd1 >= eff)) ?
                                 ST_DIV : ST_IDLE;
         ST_DIV:      if (step_ff == 7'd63) state_in = ST_RING;
         ST_RING:     state_in = ST_SUM;
         ST_SUM:      if (step_ff == 7'(ShortBlks)) state_in = ST_WDIV;
         ST_WDIV:     if (step_ff != 7'd0 && rem_ff < 64'd16) state_in = ST_OUT;
         ST_OUT:      if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = 32'sd0;
      mul_b = 32'sd0;
      case (state_ff)
         ST_M_B0:  begin mul_a = coef_ff[0]; mul_b = 32'(item_ff.sample); end
         ST_M_B1:  begin mul_a = coef_ff[1]; mul_b = 32'(item_ff.sample); end
         ST_M_A1:  begin mul_a = coef_ff[3]; mul_b = shelved_ff; end
         ST_M_B2:  begin mul_a = coef_ff[2]; mul_b = 32'(item_ff.sample); end
         ST_M_A2:  begin mul_a = coef_ff[4]; mul_b = shelved_ff; end
         ST_M_HA1: begin mul_a = coef_ff[5]; mul_b = weighted_ff; end
         ST_M_HA2: begin mul_a = coef_ff[6]; mul_b = weighted_ff; end
         ST_SQ:    begin mul_a = weighted_ff; mul_b = weighted_ff; end
         default: ;
      endcase
   end

   always_comb begin
      rd_addr = {item_ff.channel, 2'b00};
      case (state_ff)
         ST_RD1: rd_addr = {item_ff.channel, 2'b01};
         ST_RD2: rd_addr = {item_ff.channel, 2'b10};
         ST_RD3: rd_addr = {item_ff.channel, 2'b11};
         default: ;
      endcase
   end

   // filter state write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {item_ff.channel, 2'b00};
      wr_data = 48'sd0;
      case (state_ff)
         ST_S0: begin
            wr_en = 1'b1;
            wr_data = sat48(64'(acc_ff) - ((prod_ff + 64'sd2048) >>> 12) + 64'(st_ff[1]));
         end
         ST_S1: begin
            wr_en = 1'b1; wr_addr = {item_ff.channel, 2'b01};
            wr_data = sat48(64'(acc_ff) - ((prod_ff + 64'sd2048) >>> 12));
         end
         ST_S2: begin
            wr_en = 1'b1; wr_addr = {item_ff.channel, 2'b10};
            wr_data = sat48(-(64'(shelved_ff) <<< 17) - ((prod_ff + 64'sd2048) >>> 12)
                            + 64'(st_ff[3]));
         end
         ST_S3: begin
            wr_en = 1'b1; wr_addr = {item_ff.channel, 2'b11};
            wr_data = sat48((64'(shelved_ff) <<< 16) - ((prod_ff + 64'sd2048) >>> 12));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= fstate_mem[rd_addr];
      ring_rd_ff <= ring_mem[ring_rd_addr];
      if (reset) begin
         for (int i = 0; i < StateDepth; i++) fstate_mem[i] <= '0;
         for (int i = 0; i < ShortBlks; i++) ring_mem[i] <= '0;
      end else begin
         if (wr_en) fstate_mem[wr_addr] <= wr_data;
         if (state_ff == ST_RING) ring_mem[ring_pos_ff] <= quo_ff[63:48] != 16'd0 ?
                                                          48'hFFFFFFFFFFFF : quo_ff[47:0];
      end
   end

   assign ring_rd_addr = (ring_pos_ff >= RingAddrBits'(step_ff) + RingAddrBits'(1)) ?
      ring_pos_ff - RingAddrBits'(step_ff) - RingAddrBits'(1) :
      ring_pos_ff + RingAddrBits'(ShortBlks) - RingAddrBits'(step_ff) - RingAddrBits'(1);

   assign rem_try = {rem_ff, quo_ff[63]} - {1'b0, div_den_ff};

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) item_ff <= req_data;
         ST_RD1:  st_ff[0] <= rd_data_ff;
         ST_RD2:  st_ff[1] <= rd_data_ff;
         ST_RD3:  st_ff[2] <= rd_data_ff;
         ST_M_B0: st_ff[3] <= rd_data_ff;
         ST_SHELVED: shelved_ff <= to_q24(((prod_ff + 64'sd1024) >>> 11) + 64'(st_ff[0]));
         ST_M_A1: acc_ff <= 48'((prod_ff + 64'sd1024) >>> 11);
         ST_M_A2: acc_ff <= 48'((prod_ff + 64'sd1024) >>> 11);
         ST_S1: weighted_ff <= to_q24((64'(shelved_ff) <<< 16) + 64'(st_ff[2]));
         default: ;
      endcase
      if (state_ff == ST_FRAME) begin
         quo_ff     <= power_sum_ff;
         rem_ff     <= 64'd0;
         div_den_ff <= 64'(eff);
         step_ff    <= 7'd0;
      end else if (state_ff == ST_DIV) begin
         if (!rem_try[64]) begin
            rem_ff <= rem_try[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[63]};
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         step_ff <= step_ff + 7'd1;
      end else if (state_ff == ST_RING) begin
         step_ff   <= 7'd0;
         wsum_m_ff <= 54'd0;
         wsum_s_ff <= 54'd0;
      end else if (state_ff == ST_SUM) begin
         if (step_ff != 7'd0) begin
            wsum_s_ff <= wsum_s_ff + 54'(ring_rd_ff);
            if (step_ff <= 7'(MomentaryBlks)) wsum_m_ff <= wsum_m_ff + 54'(ring_rd_ff);
         end
         if (step_ff == 7'(ShortBlks)) begin
            step_ff   <= 7'd0;
            mean_m_ff <= wsum_m_ff[49:2];
         end else step_ff <= step_ff + 7'd1;
      end else if (state_ff == ST_WDIV) begin
         // halve, then reduce by fifteen: 16a + b leaves a in the quotient, a + b
         if (step_ff == 7'd0) begin
            quo_ff  <= 64'd0;
            rem_ff  <= {11'd0, wsum_s_ff[53:1]};
            step_ff <= 7'd1;
         end else if (rem_ff >= 64'd16) begin
            quo_ff <= quo_ff + {4'd0, rem_ff[63:4]};
            rem_ff <= {4'd0, rem_ff[63:4]} + {60'd0, rem_ff[3:0]};
         end else if (rem_ff == 64'd15) begin
            quo_ff <= quo_ff + 64'd1;
            rem_ff <= 64'd0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         power_sum_ff <= 64'd0;
         frame_cnt_ff <= 16'd0;
         ring_pos_ff  <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_ACC: begin
               if (power_sum_ff > ~((64'(prod_ff) + 64'd128) >> 8))
                  power_sum_ff <= '1;
               else power_sum_ff <= power_sum_ff + ((64'(prod_ff) + 64'd128) >> 8);
            end
            ST_FRAME: if (item_ff.frame_end) frame_cnt_ff <= frame_cnt_ff + 16'd1;
            ST_RING: begin
               power_sum_ff <= 64'd0;
               frame_cnt_ff <= 16'd0;
               ring_pos_ff  <= (ring_pos_ff == RingAddrBits'(ShortBlks - 1)) ?
                               '0 : ring_pos_ff + RingAddrBits'(1);
               if (done_ff < CountBits'(ShortBlks)) done_ff <= done_ff + CountBits'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.momentary_valid <= done_ff >= CountBits'(MomentaryBlks);
         rsp_ff.momentary_power <= done_ff >= CountBits'(MomentaryBlks) ? mean_m_ff : 48'd0;
         rsp_ff.short_valid     <= done_ff >= CountBits'(ShortBlks);
         rsp_ff.short_power     <= done_ff >= CountBits'(ShortBlks) ? quo_ff[47:0] : 48'd0;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/kwwp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwwp_checker
// Port-level checks of the K-weighted window power block.
// ----------------------------------------------------------------------------
module kwwp_checker import kwwp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a transaction");

   a_mom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.momentary_valid |-> rsp_data.momentary_power == 48'd0)
      else $error("momentary power without valid flag");

   a_short_implies_mom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.short_valid |-> rsp_data.momentary_valid)
      else $error("short valid before momentary valid");

endmodule

bind k_weighted_window_power kwwp_checker u_kwwp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
